// File: design/assert_macros.svh
// Assertion macros used by the ordered list engine sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define OLE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition never holds at a rising clock edge outside reset.
`define OLE_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: design/ole_pkg.sv
// Shared types and codes for the ordered list engine.
package ole_pkg;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_ROTATE,
        CELL_REMOVE
    } cell_op_t;

    localparam logic [2:0] ACT_INSERT  = 3'd0;
    localparam logic [2:0] ACT_DELETE  = 3'd1;
    localparam logic [2:0] ACT_REVERSE = 3'd2;
    localparam logic [2:0] ACT_FIND    = 3'd3;
    localparam logic [2:0] ACT_XOR     = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_REJECT    = 2'd2;

endpackage

// File: design/ordered_list_engine_unit.sv
// Ordered list engine top level: a chain of element cells under one sequencer.
// Insert, reverse, spare, rejected and empty-list actions strobe done from the execute state.
// Find, delete and xor sum scan the list first; a delete that hits then runs the remove state.
// The scan rotates the occupied cells once per cycle; busy stays high until done is strobed.
// Reset clears the length, the reversed view and the sequencer; cell contents stay undefined.
// The receiver cannot stall: each result is shown for exactly one cycle on done.
module ordered_list_engine_unit
    import ole_pkg::*;
#(
    parameter int CAPACITY = 1024
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         action,
    input  logic [9:0]         position,
    input  logic signed [31:0] value,
    output logic               done,
    output logic [1:0]         status,
    output logic signed [31:0] result_value
);

    localparam int IW = $clog2(CAPACITY);
    localparam int LW = $clog2(CAPACITY + 1);

    cell_op_t      cell_op;
    logic [IW-1:0] cell_pos;
    logic [IW-1:0] cell_last;
    logic [31:0]   cell_value;
    logic [31:0]   cell_data [CAPACITY];

    ole_ctrl #(
        .CAPACITY (CAPACITY),
        .IW       (IW),
        .LW       (LW)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .action       (action),
        .position     (position),
        .value        (value),
        .done         (done),
        .status       (status),
        .result_value (result_value),
        .head_data    (cell_data[0]),
        .cell_op      (cell_op),
        .cell_pos     (cell_pos),
        .cell_last    (cell_last),
        .cell_value   (cell_value)
    );

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic [31:0] prev_d;
        logic [31:0] next_d;

        if (g == 0)
        begin : g_first
            assign prev_d = cell_value;
        end
        else
        begin : g_mid_prev
            assign prev_d = cell_data[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_final
            assign next_d = cell_data[0];
        end
        else
        begin : g_mid_next
            assign next_d = cell_data[g+1];
        end

        ole_cell #(
            .IDX (g),
            .IW  (IW)
        ) u_cell (
            .clk       (clk),
            .op        (cell_op),
            .sel_pos   (cell_pos),
            .last      (cell_last),
            .ins_value (cell_value),
            .prev_data (prev_d),
            .next_data (next_d),
            .head_data (cell_data[0]),
            .data      (cell_data[g])
        );
    end

endmodule

// File: design/ole_cell.sv
// One storage cell of the list chain; holds one element and trades it with its neighbors.
module ole_cell
    import ole_pkg::*;
#(
    parameter int IDX = 0,
    parameter int IW  = 10
)
(
    input  logic          clk,
    input  cell_op_t      op,
    input  logic [IW-1:0] sel_pos,
    input  logic [IW-1:0] last,
    input  logic [31:0]   ins_value,
    input  logic [31:0]   prev_data,
    input  logic [31:0]   next_data,
    input  logic [31:0]   head_data,
    output logic [31:0]   data
);

    localparam logic [IW-1:0] MyIdx = IW'(IDX);

    logic [31:0] data_reg;
    logic [31:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        case (op)
            CELL_INSERT:
            begin
                if (MyIdx > sel_pos)
                begin
                    data_next = prev_data;
                end
                else if (MyIdx == sel_pos)
                begin
                    data_next = ins_value;
                end
            end
            CELL_ROTATE:
            begin
                // The last occupied cell closes the ring back to the head.
                data_next = (MyIdx == last) ? head_data : next_data;
            end
            CELL_REMOVE:
            begin
                if (MyIdx >= sel_pos)
                begin
                    data_next = next_data;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// File: design/ole_ctrl.sv
// Sequencer of the ordered list engine: decodes actions, runs scans and drives the cell chain.
`include "assert_macros.svh"
module ole_ctrl
    import ole_pkg::*;
#(
    parameter int CAPACITY = 1024,
    parameter int IW       = 10,
    parameter int LW       = 11
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         action,
    input  logic [9:0]         position,
    input  logic [31:0]        value,
    output logic               done,
    output logic [1:0]         status,
    output logic signed [31:0] result_value,
    input  logic [31:0]        head_data,
    output cell_op_t           cell_op,
    output logic [IW-1:0]      cell_pos,
    output logic [IW-1:0]      cell_last,
    output logic [31:0]        cell_value
);

    localparam int CW = (LW > 10) ? LW : 10;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_EXEC   = 4'b0010,
        S_SCAN   = 4'b0100,
        S_REMOVE = 4'b1000
    } state_t;

    state_t             state_reg, state_next;
    logic [2:0]         action_reg, action_next;
    logic [9:0]         pos_reg, pos_next;
    logic [31:0]        value_reg, value_next;
    logic [LW-1:0]      length_reg, length_next;
    logic               rev_reg, rev_next;
    logic [IW-1:0]      k_reg, k_next;
    logic [IW-1:0]      lidx_reg, lidx_next;
    logic               found_reg, found_next;
    logic [IW-1:0]      match_reg, match_next;
    logic [31:0]        acc_reg, acc_next;
    logic               done_reg, done_next;
    logic [1:0]         status_reg, status_next;
    logic [31:0]        result_reg, result_next;

    logic [IW-1:0]      last_idx;
    logic [IW-1:0]      ins_phys;
    logic               ins_bad;
    logic               hit;

    assign last_idx = IW'(length_reg - 1'b1);
    assign ins_phys = rev_reg ? IW'(length_reg - LW'(pos_reg)) : IW'(pos_reg);
    assign ins_bad  = (CW'(pos_reg) > CW'(length_reg)) || (length_reg == LW'(CAPACITY));
    assign hit      = (head_data == value_reg);

    always_comb
    begin
        state_next  = state_reg;
        action_next = action_reg;
        pos_next    = pos_reg;
        value_next  = value_reg;
        length_next = length_reg;
        rev_next    = rev_reg;
        k_next      = k_reg;
        lidx_next   = lidx_reg;
        found_next  = found_reg;
        match_next  = match_reg;
        acc_next    = acc_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        result_next = result_reg;
        cell_op     = CELL_HOLD;
        cell_pos    = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    action_next = action;
                    pos_next    = position;
                    value_next  = value;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next  = S_IDLE;
                done_next   = 1'b1;
                status_next = ST_OK;
                result_next = '0;
                case (action_reg)
                    ACT_INSERT:
                    begin
                        if (ins_bad)
                        begin
                            status_next = ST_REJECT;
                        end
                        else
                        begin
                            // In the reversed view the logical slot maps from the tail.
                            cell_op     = CELL_INSERT;
                            cell_pos    = ins_phys;
                            length_next = length_reg + 1'b1;
                        end
                    end
                    ACT_DELETE, ACT_FIND, ACT_XOR:
                    begin
                        if (length_reg == '0)
                        begin
                            if (action_reg != ACT_XOR)
                            begin
                                status_next = ST_NOT_FOUND;
                            end
                        end
                        else
                        begin
                            done_next  = 1'b0;
                            state_next = S_SCAN;
                            k_next     = '0;
                            lidx_next  = rev_reg ? last_idx : '0;
                            found_next = 1'b0;
                            acc_next   = '0;
                        end
                    end
                    ACT_REVERSE:
                    begin
                        if (length_reg > LW'(1))
                        begin
                            rev_next = !rev_reg;
                        end
                    end
                    default:
                    begin
                        status_next = ST_OK;
                    end
                endcase
            end
            S_SCAN:
            begin
                // The chain rotates once per cycle; the head cell shows physical entry k.
                cell_op   = CELL_ROTATE;
                k_next    = k_reg + 1'b1;
                lidx_next = rev_reg ? (lidx_reg - 1'b1) : (lidx_reg + 1'b1);
                acc_next  = acc_reg + (32'(lidx_reg) ^ head_data);
                // Reversed view: the last physical match is the first logical one.
                if (hit && (!found_reg || rev_reg))
                begin
                    found_next = 1'b1;
                    match_next = k_reg;
                end
                if (k_reg == last_idx)
                begin
                    state_next  = S_IDLE;
                    done_next   = 1'b1;
                    status_next = ST_OK;
                    result_next = '0;
                    case (action_reg)
                        ACT_XOR:
                        begin
                            result_next = acc_next;
                        end
                        ACT_FIND:
                        begin
                            if (found_next)
                            begin
                                result_next = rev_reg ? 32'(last_idx - match_next)
                                                      : 32'(match_next);
                            end
                            else
                            begin
                                status_next = ST_NOT_FOUND;
                            end
                        end
                        default:
                        begin
                            if (found_next)
                            begin
                                done_next  = 1'b0;
                                state_next = S_REMOVE;
                            end
                            else
                            begin
                                status_next = ST_NOT_FOUND;
                            end
                        end
                    endcase
                end
            end
            S_REMOVE:
            begin
                cell_op     = CELL_REMOVE;
                cell_pos    = match_reg;
                length_next = length_reg - 1'b1;
                state_next  = S_IDLE;
                done_next   = 1'b1;
                status_next = ST_OK;
                result_next = '0;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            length_reg <= '0;
            rev_reg    <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            length_reg <= length_next;
            rev_reg    <= rev_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg <= action_next;
        pos_reg    <= pos_next;
        value_reg  <= value_next;
        k_reg      <= k_next;
        lidx_reg   <= lidx_next;
        found_reg  <= found_next;
        match_reg  <= match_next;
        acc_reg    <= acc_next;
        status_reg <= status_next;
        result_reg <= result_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign status       = status_reg;
    assign result_value = result_reg;
    assign cell_last    = last_idx;
    assign cell_value   = value_reg;

    `OLE_NEVER(a_len_cap, length_reg > LW'(CAPACITY), "list length above capacity")
    `OLE_ASSERT(a_done_pulse, done_reg |=> !done_reg, "result strobe held two cycles")
    `OLE_ASSERT(a_scan_range, (state_reg == S_SCAN) |-> (k_reg <= last_idx), "scan ran past list end")

endmodule

// File: dv/tb_ordered_list_engine_unit.sv
// Self-checking testbench for the ordered list engine: directed table, then random actions.
`timescale 1ns / 1ps

module tb_ordered_list_engine_unit;
    import ole_pkg::*;

    localparam int CAPACITY = 1024;
    localparam int RANDOM_PER_PHASE = 185;
    localparam longint CYCLE_LIMIT = 8_000_000;
    localparam int MAX_PRINTED = 100;

    localparam logic [2:0] ACT_SPARE_5 = 3'd5;
    localparam logic [2:0] ACT_SPARE_6 = 3'd6;
    localparam logic [2:0] ACT_SPARE_7 = 3'd7;
    localparam logic [2:0] SPARE_ACTS [3] = '{ACT_SPARE_5, ACT_SPARE_6, ACT_SPARE_7};

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] result_value;
    } list_reply_t;

    typedef struct packed {
        logic [2:0]  act;
        logic [9:0]  pos;
        logic [31:0] val;
        logic        typed;
        logic [1:0]  st;
        logic [31:0] res;
    } stim_row_t;

    localparam int N_DIRECTED = 26;

    // Rows with typed set carry their own answer; the others go through the list model.
    localparam stim_row_t DIRECTED_ROWS [N_DIRECTED] = '{
        '{ACT_XOR,     10'd0,    32'h0000_0000, 1'b1, ST_OK,        32'h0},
        '{ACT_DELETE,  10'd0,    32'h0000_0005, 1'b1, ST_NOT_FOUND, 32'h0},
        '{ACT_FIND,    10'd0,    32'h8000_0000, 1'b1, ST_NOT_FOUND, 32'h0},
        '{ACT_REVERSE, 10'd0,    32'h0000_0000, 1'b1, ST_OK,        32'h0},
        '{ACT_INSERT,  10'd1,    32'h0000_0001, 1'b1, ST_REJECT,    32'h0},
        '{ACT_INSERT,  10'd1023, 32'hFFFF_FFFF, 1'b1, ST_REJECT,    32'h0},
        '{ACT_INSERT,  10'd0,    32'h7FFF_FFFF, 1'b1, ST_OK,        32'h0},
        '{ACT_REVERSE, 10'd0,    32'h0000_0000, 1'b1, ST_OK,        32'h0},
        '{ACT_FIND,    10'd0,    32'h7FFF_FFFF, 1'b1, ST_OK,        32'h0},
        '{ACT_INSERT,  10'd1,    32'h8000_0000, 1'b1, ST_OK,        32'h0},
        '{ACT_INSERT,  10'd0,    32'hFFFF_FFFF, 1'b1, ST_OK,        32'h0},
        '{ACT_INSERT,  10'd3,    32'h0000_0000, 1'b1, ST_OK,        32'h0},
        '{ACT_INSERT,  10'd5,    32'h0000_0009, 1'b1, ST_REJECT,    32'h0},
        '{ACT_XOR,     10'd0,    32'h0000_0000, 1'b0, ST_OK,        32'h0},
        '{ACT_REVERSE, 10'd0,    32'h0000_0000, 1'b1, ST_OK,        32'h0},
        '{ACT_FIND,    10'd0,    32'h8000_0000, 1'b0, ST_OK,        32'h0},
        '{ACT_XOR,     10'd0,    32'h0000_0000, 1'b0, ST_OK,        32'h0},
        '{ACT_INSERT,  10'd2,    32'h5555_5555, 1'b1, ST_OK,        32'h0},
        '{ACT_FIND,    10'd0,    32'h5555_5555, 1'b0, ST_OK,        32'h0},
        '{ACT_DELETE,  10'd0,    32'h7FFF_FFFF, 1'b1, ST_OK,        32'h0},
        '{ACT_DELETE,  10'd0,    32'h1234_5678, 1'b1, ST_NOT_FOUND, 32'h0},
        '{ACT_SPARE_5, 10'd1023, 32'hFFFF_FFFF, 1'b1, ST_OK,        32'h0},
        '{ACT_REVERSE, 10'd0,    32'h0000_0000, 1'b1, ST_OK,        32'h0},
        '{ACT_SPARE_7, 10'd0,    32'h0000_0000, 1'b1, ST_OK,        32'h0},
        '{ACT_DELETE,  10'd0,    32'h0000_0000, 1'b0, ST_OK,        32'h0},
        '{ACT_XOR,     10'd0,    32'h0000_0000, 1'b0, ST_OK,        32'h0}
    };

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [2:0]         action;
    logic [9:0]         position;
    logic signed [31:0] value;
    logic               done;
    logic [1:0]         status;
    logic signed [31:0] result_value;

    // Side band that travels with each beat: a typed answer from the table.
    logic               row_typed;
    list_reply_t        row_reply;

    // Shadow copy of the list.
    logic [31:0]        shadow_elems [CAPACITY];
    int unsigned        shadow_len;
    bit                 shadow_flipped;

    list_reply_t        list_replies [$];
    int                 mismatches;
    int                 idle_pct;
    longint             cycles;

    ordered_list_engine_unit #(
        .CAPACITY(CAPACITY)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .action(action),
        .position(position),
        .value(value),
        .done(done),
        .status(status),
        .result_value(result_value)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        if (mismatches < MAX_PRINTED)
            $display("MISMATCH at cycle %0d: %s got %h want %h", cycles, what, got, want);
        mismatches++;
    endtask

    function automatic int unsigned store_slot(input int unsigned i);
        return shadow_flipped ? (shadow_len - 1 - i) : i;
    endfunction

    // Folds a pending reversal back into the stored order.
    task automatic unflip();
        int unsigned lo;
        int unsigned hi;
        logic [31:0] t;
        if (shadow_flipped && shadow_len > 1)
        begin
            lo = 0;
            hi = shadow_len - 1;
            while (lo < hi)
            begin
                t = shadow_elems[lo];
                shadow_elems[lo] = shadow_elems[hi];
                shadow_elems[hi] = t;
                lo++;
                hi--;
            end
        end
        shadow_flipped = 1'b0;
    endtask

    function automatic bit seek_first(input logic [31:0] v, output int unsigned where);
        where = 0;
        for (int unsigned i = 0; i < shadow_len; i++)
        begin
            if (shadow_elems[store_slot(i)] == v)
            begin
                where = i;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    task automatic list_apply(input logic [2:0] act, input logic [9:0] pos,
                              input logic [31:0] val, output list_reply_t reply);
        int unsigned idx;
        reply.status = ST_OK;
        reply.result_value = '0;
        case (act)
            ACT_INSERT:
            begin
                if (pos > shadow_len || shadow_len >= CAPACITY)
                    reply.status = ST_REJECT;
                else
                begin
                    unflip();
                    for (int unsigned i = shadow_len; i > pos; i--)
                        shadow_elems[i] = shadow_elems[i - 1];
                    shadow_elems[pos] = val;
                    shadow_len++;
                end
            end
            ACT_DELETE:
            begin
                if (!seek_first(val, idx))
                    reply.status = ST_NOT_FOUND;
                else
                begin
                    unflip();
                    for (int unsigned i = idx; i + 1 < shadow_len; i++)
                        shadow_elems[i] = shadow_elems[i + 1];
                    shadow_len--;
                end
            end
            ACT_REVERSE:
            begin
                if (shadow_len > 1)
                    shadow_flipped = !shadow_flipped;
            end
            ACT_FIND:
            begin
                if (seek_first(val, idx))
                    reply.result_value = idx;
                else
                    reply.status = ST_NOT_FOUND;
            end
            ACT_XOR:
            begin
                for (int unsigned i = 0; i < shadow_len; i++)
                    reply.result_value += 32'(i) ^ shadow_elems[store_slot(i)];
            end
            default:
            begin
            end
        endcase
    endtask

    // Accepted beats are modeled here; results are checked against the oldest prediction.
    always @(posedge clk)
    begin : scoreboard
        list_reply_t want;
        list_reply_t got;
        if (rst_n)
        begin
            if (done !== 1'b0)
            begin
                if (list_replies.size() == 0)
                    flag_mismatch("result with none pending", result_value, 32'h0);
                else
                begin
                    want = list_replies.pop_front();
                    if (status !== want.status)
                        flag_mismatch("status", 32'(status), 32'(want.status));
                    if (result_value !== want.result_value)
                        flag_mismatch("result_value", result_value, want.result_value);
                end
            end
            if (start && busy === 1'b0)
            begin
                list_apply(action, position, value, got);
                if (row_typed)
                    got = row_reply;
                list_replies.push_back(got);
            end
        end
    end

    // Presents one beat at a falling edge and returns at the falling edge after acceptance.
    task automatic issue_beat(input logic [2:0] act, input logic [9:0] pos,
                              input logic [31:0] val, input logic typed,
                              input list_reply_t reply);
        while ($urandom_range(99, 0) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start     <= 1'b1;
        action    <= act;
        position  <= pos;
        value     <= val;
        row_typed <= typed;
        row_reply <= reply;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [31:0] member_value();
        if (shadow_len == 0)
            return $urandom();
        return shadow_elems[store_slot($urandom_range(shadow_len - 1, 0))];
    endfunction

    // Favors values already in the list and a small range so duplicates are common.
    function automatic logic [31:0] draw_value();
        int unsigned r;
        r = $urandom_range(99, 0);
        if (r < 55 && shadow_len > 0)
            return member_value();
        if (r < 75)
            return $urandom_range(7, 0);
        return $urandom();
    endfunction

    task automatic pick_item(output logic [2:0] act, output logic [9:0] pos,
                             output logic [31:0] val);
        int unsigned roll;
        int unsigned r2;
        roll = $urandom_range(99, 0);
        r2 = $urandom_range(99, 0);
        pos = 10'($urandom());
        val = draw_value();
        if (roll < 36)
        begin
            act = ACT_INSERT;
            if (shadow_len > 40 && r2 < 60)
            begin
                act = ACT_DELETE;
                val = member_value();
            end
            else if (r2 < 85)
                pos = 10'($urandom_range(shadow_len, 0));
            else if (r2 < 95)
                pos = 10'($urandom_range(1023, shadow_len + 1));
        end
        else if (roll < 56)
            act = ACT_DELETE;
        else if (roll < 76)
            act = ACT_FIND;
        else if (roll < 86)
            act = ACT_REVERSE;
        else if (roll < 96)
            act = ACT_XOR;
        else
            act = SPARE_ACTS[$urandom_range(2, 0)];
    endtask

    initial
    begin
        logic [2:0]  a;
        logic [9:0]  p;
        logic [31:0] v;
        list_reply_t r;
        int          phase_idle [3];

        phase_idle = '{0, 79, 19};
        rst_n = 1'b0;
        start = 1'b0;
        action = ACT_INSERT;
        position = '0;
        value = '0;
        row_typed = 1'b0;
        row_reply = '0;
        shadow_len = 0;
        shadow_flipped = 1'b0;
        mismatches = 0;
        cycles = 0;
        idle_pct = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (DIRECTED_ROWS[k])
        begin
            r.status = DIRECTED_ROWS[k].st;
            r.result_value = DIRECTED_ROWS[k].res;
            issue_beat(DIRECTED_ROWS[k].act, DIRECTED_ROWS[k].pos, DIRECTED_ROWS[k].val,
                       DIRECTED_ROWS[k].typed, r);
        end

        for (int ph = 0; ph < 3; ph++)
        begin
            idle_pct = phase_idle[ph];
            repeat (RANDOM_PER_PHASE)
            begin
                pick_item(a, p, v);
                issue_beat(a, p, v, 1'b0, '0);
            end
        end
        start <= 1'b0;

        while (list_replies.size() != 0)
            @(posedge clk);
        repeat (CAPACITY + 16) @(posedge clk);

        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
